@@ hw/rtl/stwv_pkg.sv @@
package stwv_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned ENTRY_W  = SAMPLE_W + STAMP_W;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned SQ_W     = 54;
  localparam int unsigned VAR_W    = 46;
  localparam int unsigned N_W      = 8;
  localparam int unsigned NUM_W    = SQ_W + N_W;
  localparam int unsigned SXSQ_W   = 2 * SUM_W;
  localparam int unsigned DEN_W    = 2 * N_W;
  localparam int unsigned STEP_W   = 6;

  localparam int unsigned MUL_SX_STEPS = SUM_W;
  localparam int unsigned MUL_N_STEPS  = N_W;
  localparam int unsigned DIV_STEPS    = NUM_W;

  localparam logic [47:0] AGE_LIMIT_RESET = 48'd1000000000;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_EXPIRE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic REG_AGE_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_CHK,
    S_VAR,
    S_WAIT,
    S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    V_IDLE,
    V_MUL,
    V_SUB,
    V_DIV,
    V_FIN,
    V_DONE
  } var_state_t;

  typedef struct packed {
    logic                    start;
    logic [N_W-1:0]          n;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
  } var_req_t;

endpackage

@@ hw/rtl/sliding_time_window_variance_top.sv @@
// Channel  | Ports                                   | Transfer when
// input    | in_mode, in_sample, in_now              | in_valid && in_ready
// result   | out_count .. out_last_sample            | out_valid && out_ready
// config   | psel, penable, pwrite, paddr, pwdata    | psel && penable && pwrite
//
// One item at a time: an add or expire checks the oldest entry in S_EXP and S_CHK and
// evicts while due, then the variance unit runs (serial 32-step square, subtract, 62-step
// division; skipped below two samples) and the result is loaded in S_OUT.
// Reset (rst_n low at a clock edge) empties the window; the ring memory holds
// no reset value. A stalled result holds the next one back, but a new item is
// taken while a finished result waits.
module sliding_time_window_variance_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic signed [23:0] in_sample,
  input  logic [47:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_count,
  output logic signed [31:0] out_window_sum,
  output logic [53:0] out_window_square_sum,
  output logic [45:0] out_variance,
  output logic signed [23:0] out_last_sample,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  stwv_pkg::top_state_t state_r, state_nxt;

  logic [stwv_pkg::IDX_W-1:0]    head_r, head_nxt;
  logic [stwv_pkg::IDX_W-1:0]    tail_r, tail_nxt;
  logic [stwv_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [stwv_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [stwv_pkg::SQ_W-1:0]     sq_r, sq_nxt;
  logic signed [23:0]            last_r, last_nxt;
  logic [47:0]                   thr_r, thr_nxt;
  logic                          ok_r, ok_nxt;
  logic [47:0]                   age_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_count_r, out_count_nxt;
  logic [31:0]                   out_sum_r, out_sum_nxt;
  logic [53:0]                   out_sq_r, out_sq_nxt;
  logic [45:0]                   out_var_r, out_var_nxt;
  logic [23:0]                   out_last_r, out_last_nxt;

  logic                          in_fire;
  logic                          cfg_write;
  logic [stwv_pkg::ENTRY_W-1:0]  rd_data;
  logic signed [23:0]            rd_sample;
  logic [47:0]                   rd_stamp;
  logic                          drop;
  logic                          load_out;
  logic signed [23:0]            sq_op;
  logic [47:0]                   square;
  logic                          var_done;
  logic [45:0]                   var_value;
  stwv_pkg::var_req_t            var_req;

  assign in_ready  = (state_r == stwv_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && (paddr[3] == stwv_pkg::REG_AGE_LIMIT);

  stwv_ram #(
    .WIDTH(stwv_pkg::ENTRY_W),
    .DEPTH(stwv_pkg::DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (in_fire && (in_mode == stwv_pkg::MODE_ADD)),
    .wr_addr(head_r),
    .wr_data({in_sample, in_now}),
    .rd_addr(tail_r),
    .rd_data(rd_data)
  );

  assign rd_sample = rd_data[stwv_pkg::ENTRY_W-1:stwv_pkg::STAMP_W];
  assign rd_stamp  = rd_data[stwv_pkg::STAMP_W-1:0];

  // One squarer serves both the incoming and the evicted sample.
  assign sq_op  = (state_r == stwv_pkg::S_CHK) ? rd_sample : in_sample;
  assign square = 48'(sq_op * sq_op);

  assign drop = (count_r >= stwv_pkg::CNT_W'(stwv_pkg::DEPTH))
             || (ok_r && (rd_stamp < thr_r));

  assign load_out = (state_r == stwv_pkg::S_OUT) && (!out_valid_r || out_ready);

  assign var_req.start = (state_r == stwv_pkg::S_VAR);
  assign var_req.n     = 8'(count_r);
  assign var_req.sum   = sum_r;
  assign var_req.sq    = sq_r;

  stwv_var_unit u_var (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (var_req),
    .done    (var_done),
    .variance(var_value)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stwv_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_mode == stwv_pkg::MODE_ADD || in_mode == stwv_pkg::MODE_EXPIRE)
                    ? stwv_pkg::S_EXP : stwv_pkg::S_VAR;
        end
      end
      stwv_pkg::S_EXP:  state_nxt = (count_r == '0) ? stwv_pkg::S_VAR : stwv_pkg::S_CHK;
      stwv_pkg::S_CHK:  state_nxt = drop ? stwv_pkg::S_EXP : stwv_pkg::S_VAR;
      stwv_pkg::S_VAR:  state_nxt = stwv_pkg::S_WAIT;
      stwv_pkg::S_WAIT: begin
        if (var_done) begin
          state_nxt = stwv_pkg::S_OUT;
        end
      end
      stwv_pkg::S_OUT: begin
        if (load_out) begin
          state_nxt = stwv_pkg::S_IDLE;
        end
      end
      default: state_nxt = stwv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    last_nxt  = last_r;
    thr_nxt   = thr_r;
    ok_nxt    = ok_r;
    unique case (state_r)
      stwv_pkg::S_IDLE: begin
        if (in_fire) begin
          thr_nxt = in_now - age_r;
          ok_nxt  = (in_now >= age_r);
          if (in_mode == stwv_pkg::MODE_ADD) begin
            head_nxt  = (head_r == stwv_pkg::IDX_W'(stwv_pkg::DEPTH - 1)) ? '0
                      : head_r + 1'b1;
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + stwv_pkg::SUM_W'(in_sample);
            sq_nxt    = sq_r + stwv_pkg::SQ_W'(square);
            last_nxt  = in_sample;
          end else if (in_mode == stwv_pkg::MODE_CLEAR) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
            sum_nxt   = '0;
            sq_nxt    = '0;
          end
        end
      end
      stwv_pkg::S_CHK: begin
        if (drop) begin
          tail_nxt  = (tail_r == stwv_pkg::IDX_W'(stwv_pkg::DEPTH - 1)) ? '0
                    : tail_r + 1'b1;
          count_nxt = count_r - 1'b1;
          sum_nxt   = sum_r - stwv_pkg::SUM_W'(rd_sample);
          sq_nxt    = sq_r - stwv_pkg::SQ_W'(square);
        end
      end
      stwv_pkg::S_EXP, stwv_pkg::S_VAR, stwv_pkg::S_WAIT, stwv_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_sum_nxt   = out_sum_r;
    out_sq_nxt    = out_sq_r;
    out_var_nxt   = out_var_r;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = 8'(count_r);
      out_sum_nxt   = sum_r;
      out_sq_nxt    = sq_r;
      out_var_nxt   = var_value;
      out_last_nxt  = (count_r == '0) ? '0 : last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stwv_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      age_r       <= stwv_pkg::AGE_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        age_r <= pwdata[47:0];
      end
    end
    last_r      <= last_nxt;
    thr_r       <= thr_nxt;
    ok_r        <= ok_nxt;
    out_count_r <= out_count_nxt;
    out_sum_r   <= out_sum_nxt;
    out_sq_r    <= out_sq_nxt;
    out_var_r   <= out_var_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_count             = out_count_r;
  assign out_window_sum        = out_sum_r;
  assign out_window_square_sum = out_sq_r;
  assign out_variance          = out_var_r;
  assign out_last_sample       = out_last_r;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == stwv_pkg::REG_AGE_LIMIT) ? {16'd0, age_r} : 64'd0;

endmodule

@@ hw/rtl/stwv_ram.sv @@
module stwv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/stwv_var_unit.sv @@
module stwv_var_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stwv_pkg::var_req_t             req,
  output logic                           done,
  output logic [stwv_pkg::VAR_W-1:0]     variance
);

  stwv_pkg::var_state_t state_r, state_nxt;

  logic [stwv_pkg::SXSQ_W-1:0]  acc_sx_r, acc_sx_nxt;
  logic [stwv_pkg::NUM_W-1:0]   acc_n_r, acc_n_nxt;
  logic [stwv_pkg::SQ_W-1:0]    sq_r, sq_nxt;
  logic [stwv_pkg::N_W-1:0]     n_r, n_nxt;
  logic [stwv_pkg::SUM_W-1:0]   mag_r, mag_nxt;
  logic [stwv_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [stwv_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [stwv_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [stwv_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [stwv_pkg::VAR_W-1:0]   res_r, res_nxt;

  logic [stwv_pkg::SUM_W-1:0]   mag;
  logic [stwv_pkg::SUM_W:0]     sx_sum;
  logic [stwv_pkg::SQ_W:0]      n_part;
  logic [stwv_pkg::DEN_W:0]     shifted;
  logic                         fits;

  assign mag = req.sum[stwv_pkg::SUM_W-1] ? stwv_pkg::SUM_W'(-req.sum)
                                          : stwv_pkg::SUM_W'(req.sum);

  // Shift-and-add multipliers: the multiplier sits in the low half of the
  // accumulator and leaves one bit per cycle as the product moves in.
  assign sx_sum = {1'b0, acc_sx_r[stwv_pkg::SXSQ_W-1:stwv_pkg::SUM_W]}
                + (acc_sx_r[0] ? {1'b0, mag_r} : '0);
  assign n_part = {1'b0, acc_n_r[stwv_pkg::NUM_W-1:stwv_pkg::N_W]}
                + (acc_n_r[0] ? {1'b0, sq_r} : '0);

  assign shifted = {rem_r, quo_r[stwv_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stwv_pkg::V_IDLE: begin
        if (req.start) begin
          state_nxt = (req.n < stwv_pkg::N_W'(2)) ? stwv_pkg::V_DONE : stwv_pkg::V_MUL;
        end
      end
      stwv_pkg::V_MUL: begin
        if (step_r == stwv_pkg::STEP_W'(stwv_pkg::MUL_SX_STEPS - 1)) begin
          state_nxt = stwv_pkg::V_SUB;
        end
      end
      stwv_pkg::V_SUB: begin
        state_nxt = (stwv_pkg::SXSQ_W'(acc_n_r) < acc_sx_r) ? stwv_pkg::V_DONE
                                                            : stwv_pkg::V_DIV;
      end
      stwv_pkg::V_DIV: begin
        if (step_r == stwv_pkg::STEP_W'(stwv_pkg::DIV_STEPS - 1)) begin
          state_nxt = stwv_pkg::V_FIN;
        end
      end
      stwv_pkg::V_FIN:  state_nxt = stwv_pkg::V_DONE;
      stwv_pkg::V_DONE: state_nxt = stwv_pkg::V_IDLE;
      default:          state_nxt = stwv_pkg::V_IDLE;
    endcase
  end

  always_comb begin
    acc_sx_nxt = acc_sx_r;
    acc_n_nxt  = acc_n_r;
    sq_nxt     = sq_r;
    n_nxt      = n_r;
    mag_nxt    = mag_r;
    step_nxt   = step_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    res_nxt    = res_r;
    unique case (state_r)
      stwv_pkg::V_IDLE: begin
        if (req.start) begin
          acc_sx_nxt = {{stwv_pkg::SUM_W{1'b0}}, mag};
          acc_n_nxt  = {{stwv_pkg::SQ_W{1'b0}}, req.n};
          mag_nxt    = mag;
          sq_nxt     = req.sq;
          n_nxt      = req.n;
          step_nxt   = '0;
          res_nxt    = '0;
        end
      end
      stwv_pkg::V_MUL: begin
        acc_sx_nxt = {sx_sum, acc_sx_r[stwv_pkg::SUM_W-1:1]};
        if (step_r < stwv_pkg::STEP_W'(stwv_pkg::MUL_N_STEPS)) begin
          acc_n_nxt = {n_part, acc_n_r[stwv_pkg::N_W-1:1]};
        end
        step_nxt = step_r + 1'b1;
      end
      stwv_pkg::V_SUB: begin
        quo_nxt  = acc_n_r - stwv_pkg::NUM_W'(acc_sx_r);
        den_nxt  = n_r * (n_r - 1'b1);
        rem_nxt  = '0;
        step_nxt = '0;
        res_nxt  = '0;
      end
      stwv_pkg::V_DIV: begin
        rem_nxt  = fits ? stwv_pkg::DEN_W'(shifted - {1'b0, den_r})
                        : shifted[stwv_pkg::DEN_W-1:0];
        quo_nxt  = {quo_r[stwv_pkg::NUM_W-2:0], fits};
        step_nxt = step_r + 1'b1;
      end
      stwv_pkg::V_FIN: begin
        res_nxt = (quo_r[stwv_pkg::NUM_W-1:stwv_pkg::VAR_W] != '0) ? '1
                : quo_r[stwv_pkg::VAR_W-1:0];
      end
      stwv_pkg::V_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stwv_pkg::V_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_sx_r <= acc_sx_nxt;
    acc_n_r  <= acc_n_nxt;
    sq_r     <= sq_nxt;
    n_r      <= n_nxt;
    mag_r    <= mag_nxt;
    step_r   <= step_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    res_r    <= res_nxt;
  end

  assign done     = (state_r == stwv_pkg::V_DONE);
  assign variance = res_r;

endmodule

@@ hw/rtl/stwv_checker.sv @@
module stwv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_count,
  input logic [31:0] out_window_sum,
  input logic [53:0] out_window_square_sum,
  input logic [45:0] out_variance,
  input logic [23:0] out_last_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_small_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count < 8'd2) |-> out_variance == 46'd0)
    else $error("variance nonzero with fewer than two samples");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == 8'd0) |->
      (out_window_sum == 32'd0) && (out_window_square_sum == 54'd0)
      && (out_last_sample == 24'd0))
    else $error("empty window reports data");

endmodule

bind sliding_time_window_variance_top stwv_checker u_stwv_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_count            (out_count),
  .out_window_sum       (out_window_sum),
  .out_window_square_sum(out_window_square_sum),
  .out_variance         (out_variance),
  .out_last_sample      (out_last_sample)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int RING = 256;

  typedef struct packed {
    logic [7:0]         count;
    logic signed [31:0] wsum;
    logic [53:0]        wsq;
    logic [45:0]        var_q;
    logic signed [23:0] last;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = stwv_pkg::MODE_ADD;
  logic signed [23:0] in_sample = '0;
  logic [47:0] in_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_count;
  logic signed [31:0] out_window_sum;
  logic [53:0] out_window_square_sum;
  logic [45:0] out_variance;
  logic signed [23:0] out_last_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  sliding_time_window_variance_top dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [23:0] win_sample [RING];
  logic [47:0] win_stamp [RING];
  int unsigned win_head, win_tail, win_held;
  logic [31:0] win_sum = '0;
  logic [53:0] win_sq = '0;
  logic [47:0] win_age = stwv_pkg::AGE_LIMIT_RESET;

  window_stats_t stats_queue[$];
  int errors = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  logic [47:0] clock_now = 48'd0;

  function automatic logic [53:0] square24(logic [23:0] raw);
    longint s;
    s = longint'($signed(raw));
    return 54'(s * s);
  endfunction

  function automatic void evict_oldest();
    win_sum = win_sum - 32'($signed(win_sample[win_tail]));
    win_sq = win_sq - square24(win_sample[win_tail]);
    win_tail = (win_tail + 1) % RING;
    win_held--;
  endfunction

  function automatic void age_out(logic [47:0] t);
    forever begin
      if (win_held >= RING) evict_oldest();
      else if (win_held == 0) break;
      else if (t >= win_age && win_stamp[win_tail] < t - win_age) evict_oldest();
      else break;
    end
  endfunction

  function automatic logic [45:0] window_variance();
    longint sx;
    logic [63:0] mag, sxsq, num, den, q;
    if (win_held < 2) return '0;
    sx = longint'($signed(win_sum));
    mag = sx < 0 ? 64'(-sx) : 64'(sx);
    sxsq = mag * mag;
    num = 64'(win_held) * 64'(win_sq);
    if (num < sxsq) return '0;
    num = num - sxsq;
    den = 64'(win_held) * 64'(win_held - 1);
    q = num / den;
    return q > 64'h3FFF_FFFF_FFFF ? 46'h3FFF_FFFF_FFFF : q[45:0];
  endfunction

  function automatic window_stats_t predict_window(logic [1:0] m, logic [23:0] s,
                                                   logic [47:0] t);
    window_stats_t r;
    if (m == stwv_pkg::MODE_ADD) begin
      win_sample[win_head] = s;
      win_stamp[win_head] = t;
      win_held++;
      win_sum = win_sum + 32'($signed(s));
      win_sq = win_sq + square24(s);
      win_head = (win_head + 1) % RING;
      age_out(t);
    end else if (m == stwv_pkg::MODE_EXPIRE) begin
      age_out(t);
    end else if (m == stwv_pkg::MODE_CLEAR) begin
      win_head = 0;
      win_tail = 0;
      win_held = 0;
      win_sum = '0;
      win_sq = '0;
    end
    r.count = 8'(win_held);
    r.wsum = win_sum;
    r.wsq = win_sq;
    r.var_q = window_variance();
    r.last = win_held == 0 ? '0 : win_sample[(win_head + RING - 1) % RING];
    return r;
  endfunction

  task automatic send_item(logic [1:0] m, logic [23:0] s, logic [47:0] t);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    stats_queue.push_back(predict_window(m, s, t));
    in_valid <= 1'b1;
    in_mode <= m;
    in_sample <= s;
    in_now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (stats_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [47:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(stwv_pkg::REG_AGE_LIMIT) * 4'd8;
    pwdata <= 64'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_age = v;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(15)) - 24'd8;
      default: return 24'($urandom);
    endcase
  endfunction

  // Time normally advances; a few stamps are fully random to reach high bits.
  task automatic send_random(int n, int gap_max);
    logic [1:0] m;
    logic [47:0] t;
    repeat (n) begin
      case ($urandom_range(19))
        0: m = stwv_pkg::MODE_CLEAR;
        1, 2, 3: m = stwv_pkg::MODE_EXPIRE;
        4: m = stwv_pkg::MODE_RESERVED;
        default: m = stwv_pkg::MODE_ADD;
      endcase
      clock_now = clock_now + 48'($urandom_range(gap_max));
      t = ($urandom_range(49) == 0) ? {16'($urandom), 32'($urandom)} : clock_now;
      send_item(m, rand_sample(), t);
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_n && out_valid && out_ready) begin
      window_stats_t got, want;
      got = '{out_count, out_window_sum, out_window_square_sum, out_variance,
              out_last_sample};
      results_seen <= results_seen + 1;
      if (stats_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors = errors + 1;
      end else begin
        want = stats_queue.pop_front();
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          errors = errors + 1;
        end
        if (got.wsum !== want.wsum) begin
          $display("%0t: sum expected %0d actual %0d", $time, want.wsum, got.wsum);
          errors = errors + 1;
        end
        if (got.wsq !== want.wsq) begin
          $display("%0t: square sum expected %0d actual %0d", $time, want.wsq, got.wsq);
          errors = errors + 1;
        end
        if (got.var_q !== want.var_q) begin
          $display("%0t: variance expected %0d actual %0d", $time, want.var_q,
                   got.var_q);
          errors = errors + 1;
        end
        if (got.last !== want.last) begin
          $display("%0t: last sample expected %0d actual %0d", $time, want.last,
                   got.last);
          errors = errors + 1;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(stwv_pkg::MODE_EXPIRE, '0, 48'd0);
    send_item(stwv_pkg::MODE_ADD, 24'h7FFFFF, 48'd10);
    send_item(stwv_pkg::MODE_ADD, 24'h800000, 48'd11);
    send_item(stwv_pkg::MODE_ADD, 24'h000001, 48'd12);
    send_item(stwv_pkg::MODE_RESERVED, 24'h123456, 48'd13);
    send_item(stwv_pkg::MODE_CLEAR, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(stwv_pkg::MODE_EXPIRE, '0, 48'd5);
    send_item(stwv_pkg::MODE_ADD, 24'hFFFFFF, 48'd100);
    send_item(stwv_pkg::MODE_ADD, 24'h000000, 48'd100);
    // Now is below the age limit, so nothing expires.
    send_item(stwv_pkg::MODE_EXPIRE, '0, 48'd999);
    send_item(stwv_pkg::MODE_ADD, 24'h555555, 48'hFFFF_FFFF_FFFF);
    send_item(stwv_pkg::MODE_ADD, 24'hAAAAAA, 48'hFFFF_FFFF_FFFF);
  endtask

  task automatic test_age_limits();
    write_age_limit(48'd0);
    send_item(stwv_pkg::MODE_ADD, 24'd7, 48'd50);
    send_item(stwv_pkg::MODE_ADD, 24'd9, 48'd50);
    send_item(stwv_pkg::MODE_ADD, 24'd3, 48'd51);
    send_item(stwv_pkg::MODE_EXPIRE, '0, 48'd52);
    write_age_limit(48'hFFFF_FFFF_FFFF);
    send_item(stwv_pkg::MODE_ADD, 24'd1, 48'd0);
    send_item(stwv_pkg::MODE_EXPIRE, '0, 48'hFFFF_FFFF_FFFF);
    send_item(stwv_pkg::MODE_CLEAR, '0, '0);
    write_age_limit(48'd300);
    clock_now = 48'd1000;
    send_random(100, 8);
  endtask

  // Ring overflow: many adds with no expiry by age.
  task automatic test_full_ring();
    write_age_limit(48'hFFFF_FFFF_FFFF);
    send_item(stwv_pkg::MODE_CLEAR, '0, '0);
    repeat (270) send_item(stwv_pkg::MODE_ADD, rand_sample(), 48'd1);
  endtask

  task automatic test_back_pressure();
    write_age_limit(48'd2000);
    hold_cycles = 2000;
    send_random(20, 40);
    drain();
    send_random(10, 40);
  endtask

  task automatic test_random_phases();
    write_age_limit(48'd500);
    send_random(120, 30);
    send_idle_pct = 71;
    send_random(100, 30);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    send_random(100, 30);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    write_age_limit(48'($urandom_range(5000)));
    send_random(100, 60);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_age_limits();
    test_full_ring();
    test_back_pressure();
    test_random_phases();
    drain();
    $display("Covered adds, expiry, clears, the unused mode, ring overflow and");
    $display("%0d results under several age limits and stall patterns.", results_seen);
    if (errors == 0 && stats_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 1500000);
    $display("FAIL");
    $finish;
  end

endmodule

@@ sliding_time_window_variance_top.f @@
hw/rtl/stwv_pkg.sv
hw/rtl/stwv_ram.sv
hw/rtl/stwv_var_unit.sv
hw/rtl/sliding_time_window_variance_top.sv
hw/rtl/stwv_checker.sv
tb/testbench.sv
